// File: design/hbt_pkg.sv
`default_nettype none
package hbt_pkg;

   typedef enum logic [1:0] {
      KIND_STAMP = 2'd0,
      KIND_TICK  = 2'd1,
      KIND_TAKE  = 2'd2,
      KIND_READ  = 2'd3
   } kind_type;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_BAD     = 2'd1;
   localparam logic [1:0] STATUS_NONE    = 2'd2;
   localparam int         MAX_READ_BYTES = 8;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_EMIT
   } state_type;

   // broadcast to every cell
   typedef struct packed {
      kind_type    kind;
      logic        stamp;
      logic        tick;
      logic [7:0]  addr;
      logic [7:0]  dev_type;
      logic        has_data;
      logic [7:0]  data;
      logic [2:0]  index;
   } cmd_type;

   // word handed from cell to cell during a scan
   typedef struct packed {
      logic        valid;
      logic [5:0]  count;
      logic        found;
      logic [7:0]  addr;
      logic [7:0]  dev_type;
      logic [15:0] elapsed;
      logic        mark;
      logic [MAX_READ_BYTES-1:0][7:0] bytes;
   } link_type;

endpackage
`default_nettype wire

// File: design/node_heartbeat_timeout_table.sv
// Heartbeat table with one cell per node. start is taken while busy is low;
// the scan word then walks down the cell chain one cell per cycle from the
// highest entry to entry 0, and results follow (one, or min(DATA_BYTES, 8)
// for an entry readout) as single-cycle rsp_valid strobes with rsp_last on
// the final one; the receiver has no way to stall them and must take each
// when shown. The timeout_limit register is written via the csr_ channel;
// the user must write it only while idle, as the block does not enforce this.
`default_nettype none
module node_heartbeat_timeout_table #(
   parameter int DEVICES    = 32,
   parameter int DATA_BYTES = 8,
   parameter int TIMER_BITS = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic [1:0] req_kind,
   input  wire logic [7:0] req_device_addr,
   input  wire logic [7:0] req_device_type,
   input  wire logic       req_has_data,
   input  wire logic [7:0] req_data_byte,
   input  wire logic [2:0] req_byte_index,
   input  wire logic       req_last_byte,
   output logic            rsp_valid,
   output logic [1:0]      rsp_status,
   output logic [7:0]      rsp_entry_addr,
   output logic [7:0]      rsp_entry_type,
   output logic [15:0]     rsp_elapsed,
   output logic            rsp_reported,
   output logic [7:0]      rsp_out_byte,
   output logic [2:0]      rsp_out_index,
   output logic            rsp_last,
   output logic [5:0]      rsp_failed_count,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [15:0] csr_data
);
   import hbt_pkg::*;

   localparam int READ_BYTES = (DATA_BYTES < MAX_READ_BYTES) ? DATA_BYTES : MAX_READ_BYTES;

   state_type   state_ff, state_in;
   cmd_type     cmd_ff, cmd_in;
   logic [15:0] limit_ff;
   link_type    res_ff;
   logic [2:0]  bcnt_ff, bcnt_in;
   logic        launch_ff;

   cmd_type     cmd_bus;
   link_type    head_link;
   link_type    link [DEVICES+1];
   logic        addr_bad, short_rsp, emit_last;
   logic [1:0]  status;

   // stamp item's last_byte marker changes nothing
   logic unused_last_byte;
   assign unused_last_byte = req_last_byte;

   assign csr_ready = 1'b1;
   assign busy      = state_ff != ST_IDLE;

   always_comb begin
      cmd_in = cmd_ff;
      if (start && !busy) begin
         cmd_in.kind     = kind_type'(req_kind);
         cmd_in.addr     = req_device_addr;
         cmd_in.dev_type = req_device_type;
         cmd_in.has_data = req_has_data;
         cmd_in.data     = req_data_byte;
         cmd_in.index    = req_byte_index;
      end
      cmd_in.stamp = 1'b0;
      cmd_in.tick  = 1'b0;
   end

   assign addr_bad = (cmd_ff.addr == 8'd0) || (32'(cmd_ff.addr) > DEVICES);

   always_comb begin
      cmd_bus       = cmd_ff;
      cmd_bus.stamp = (state_ff == ST_START) && (cmd_ff.kind == KIND_STAMP) && !addr_bad;
      cmd_bus.tick  = (state_ff == ST_START) && (cmd_ff.kind == KIND_TICK);
   end

   always_comb begin
      head_link       = '0;
      head_link.valid = launch_ff;
   end

   assign link[DEVICES] = head_link;

   for (genvar i = 0; i < DEVICES; i++) begin : g_cell
      hbt_cell #(
         .IDX       (i),
         .DATA_BYTES(DATA_BYTES),
         .TIMER_BITS(TIMER_BITS)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .cmd     (cmd_bus),
         .limit   (limit_ff),
         .link_in (link[i+1]),
         .link_out(link[i])
      );
   end

   always_comb begin
      case (cmd_ff.kind)
         KIND_STAMP: status = addr_bad ? STATUS_BAD : STATUS_OK;
         KIND_TICK:  status = STATUS_OK;
         KIND_TAKE:  status = res_ff.found ? STATUS_OK : STATUS_NONE;
         KIND_READ:  status = addr_bad ? STATUS_BAD : STATUS_OK;
         default:    status = STATUS_OK;
      endcase
   end

   assign short_rsp = (status != STATUS_OK) || (cmd_ff.kind == KIND_STAMP)
                      || (cmd_ff.kind == KIND_TICK);
   assign emit_last = short_rsp || (bcnt_ff == 3'(READ_BYTES - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      bcnt_in  = bcnt_ff;
      case (state_ff)
         ST_IDLE:  if (start) state_in = ST_START;
         ST_START: state_in = ST_SCAN;
         ST_SCAN: begin
            bcnt_in = '0;
            if (link[0].valid) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            bcnt_in = bcnt_ff + 3'd1;
            if (emit_last) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      rsp_valid        = 1'b0;
      rsp_status       = status;
      rsp_entry_addr   = '0;
      rsp_entry_type   = '0;
      rsp_elapsed      = '0;
      rsp_reported     = 1'b0;
      rsp_out_byte     = '0;
      rsp_out_index    = '0;
      rsp_last         = emit_last;
      rsp_failed_count = res_ff.count;
      case (state_ff)
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (!short_rsp) begin
               rsp_entry_addr = res_ff.addr;
               rsp_entry_type = res_ff.dev_type;
               rsp_elapsed    = res_ff.elapsed;
               rsp_reported   = res_ff.mark;
               rsp_out_byte   = res_ff.bytes[bcnt_ff];
               rsp_out_index  = bcnt_ff;
            end
         end
         default: rsp_valid = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         limit_ff  <= 16'd1000;
         launch_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         launch_ff <= state_ff == ST_START;
         if (csr_valid && csr_ready)
            limit_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      bcnt_ff <= bcnt_in;
      if (state_ff == ST_SCAN && link[0].valid)
         res_ff <= link[0];
   end

endmodule
`default_nettype wire

// File: design/hbt_cell.sv
`default_nettype none
module hbt_cell #(
   parameter int IDX        = 0,
   parameter int DATA_BYTES = 8,
   parameter int TIMER_BITS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire hbt_pkg::cmd_type  cmd,
   input  wire logic [15:0]       limit,
   input  wire hbt_pkg::link_type link_in,
   output hbt_pkg::link_type      link_out
);
   import hbt_pkg::*;

   localparam int READ_BYTES = (DATA_BYTES < MAX_READ_BYTES) ? DATA_BYTES : MAX_READ_BYTES;

   logic [7:0]            addr_ff, addr_in;
   logic [7:0]            type_ff, type_in;
   logic [TIMER_BITS-1:0] cnt_ff, cnt_in;
   logic                  mark_ff, mark_in;
   logic [DATA_BYTES-1:0][7:0] bytes_ff, bytes_in;
   link_type              link_ff, link_in_n;

   logic        hit, failed, claim;
   logic [31:0] cnt_wide;
   logic [15:0] elapsed;

   assign hit      = cmd.addr == 8'(IDX + 1);
   assign cnt_wide = 32'(cnt_ff);
   assign failed   = cnt_wide > 32'(limit);
   assign elapsed  = (cnt_wide > 32'hFFFF) ? 16'hFFFF : cnt_wide[15:0];

   always_comb begin
      claim = 1'b0;
      if (link_in.valid && !link_in.found) begin
         if (cmd.kind == KIND_TAKE)
            claim = failed && !mark_ff;
         else if (cmd.kind == KIND_READ)
            claim = hit;
      end
   end

   always_comb begin
      addr_in  = addr_ff;
      type_in  = type_ff;
      cnt_in   = cnt_ff;
      mark_in  = mark_ff;
      bytes_in = bytes_ff;
      if (cmd.stamp && hit) begin
         addr_in = cmd.addr;
         type_in = cmd.dev_type;
         cnt_in  = '0;
         mark_in = 1'b0;
         if (cmd.has_data && (32'(cmd.index) < DATA_BYTES))
            bytes_in[cmd.index] = cmd.data;
      end else if (cmd.tick && (cnt_ff != '1)) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (claim && (cmd.kind == KIND_TAKE)) begin
         mark_in = 1'b1;
      end
   end

   always_comb begin
      link_in_n       = link_in;
      link_in_n.count = (link_in.count == 6'd63) ? link_in.count
                                                 : link_in.count + 6'(failed);
      if (claim) begin
         link_in_n.found    = 1'b1;
         link_in_n.addr     = addr_ff;
         link_in_n.dev_type = type_ff;
         link_in_n.elapsed  = elapsed;
         // a taken entry is reported with its new mark
         link_in_n.mark     = mark_ff || (cmd.kind == KIND_TAKE);
         link_in_n.bytes    = '0;
         for (int k = 0; k < READ_BYTES; k++)
            link_in_n.bytes[k] = bytes_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff  <= '0;
         type_ff  <= '0;
         cnt_ff   <= '0;
         mark_ff  <= 1'b0;
         bytes_ff <= '0;
         link_ff  <= '0;
      end else begin
         addr_ff  <= addr_in;
         type_ff  <= type_in;
         cnt_ff   <= cnt_in;
         mark_ff  <= mark_in;
         bytes_ff <= bytes_in;
         link_ff  <= link_in_n;
      end
   end

   assign link_out = link_ff;

endmodule
`default_nettype wire

// File: design/hbt_checker.sv
`default_nettype none
module hbt_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic       rsp_valid,
   input wire logic       rsp_last,
   input wire logic [1:0] rsp_status
);
   import hbt_pkg::*;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy not raised after accept");

   a_rsp_in_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result shown while idle");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid) else $error("result after last word");

   a_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid) else $error("gap inside entry readout");

   a_err_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> rsp_last)
      else $error("error status on a non-final word");

endmodule

bind node_heartbeat_timeout_table hbt_checker u_hbt_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_last  (rsp_last),
   .rsp_status(rsp_status)
);
`default_nettype wire

// File: sim/tb_node_heartbeat_timeout_table.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_node_heartbeat_timeout_table;
   import hbt_pkg::*;

   localparam int NODES     = 32;
   localparam int READ_LEN  = 8;
   localparam int TIMER_TOP = 65535;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] addr;
      logic [7:0] dev_type;
      logic       has_data;
      logic [7:0] data;
      logic [2:0] index;
      logic       last_byte;
   } hb_cmd_t;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  entry_addr;
      logic [7:0]  entry_type;
      logic [15:0] elapsed;
      logic        reported;
      logic [7:0]  out_byte;
      logic [2:0]  out_index;
      logic        last;
      logic [5:0]  failed_count;
   } hb_rsp_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_kind = '0;
   logic [7:0] req_device_addr = '0;
   logic [7:0] req_device_type = '0;
   logic req_has_data = 1'b0;
   logic [7:0] req_data_byte = '0;
   logic [2:0] req_byte_index = '0;
   logic req_last_byte = 1'b0;
   logic rsp_valid;
   logic [1:0] rsp_status;
   logic [7:0] rsp_entry_addr;
   logic [7:0] rsp_entry_type;
   logic [15:0] rsp_elapsed;
   logic rsp_reported;
   logic [7:0] rsp_out_byte;
   logic [2:0] rsp_out_index;
   logic rsp_last;
   logic [5:0] rsp_failed_count;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [15:0] csr_data = '0;

   node_heartbeat_timeout_table u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_device_addr(req_device_addr),
      .req_device_type(req_device_type), .req_has_data(req_has_data),
      .req_data_byte(req_data_byte), .req_byte_index(req_byte_index),
      .req_last_byte(req_last_byte), .rsp_valid(rsp_valid),
      .rsp_status(rsp_status), .rsp_entry_addr(rsp_entry_addr),
      .rsp_entry_type(rsp_entry_type), .rsp_elapsed(rsp_elapsed),
      .rsp_reported(rsp_reported), .rsp_out_byte(rsp_out_byte),
      .rsp_out_index(rsp_out_index), .rsp_last(rsp_last),
      .rsp_failed_count(rsp_failed_count), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #10 clock = ~clock;

   // predictor copy of the table
   logic [15:0] limit_q;
   logic [7:0]  node_addr_q [NODES];
   logic [7:0]  node_type_q [NODES];
   logic [15:0] ticks_q [NODES];
   logic        mark_q [NODES];
   logic [7:0]  bytes_q [NODES][READ_LEN];

   hb_cmd_t pending_cmds[$];
   hb_rsp_t expected_rsps[$];
   int      errors = 0;
   int      accepted = 0;
   bit      quiet_drive = 1'b0;
   // word taken at the last rising edge
   logic    accept_seen = 1'b0;

   function automatic logic [5:0] count_timed_out();
      int n;
      n = 0;
      for (int i = 0; i < NODES; i++)
         if (ticks_q[i] > limit_q) n++;
      return (n > 63) ? 6'd63 : 6'(n);
   endfunction

   function automatic void push_short(logic [1:0] st);
      hb_rsp_t r;
      r = '0;
      r.status = st;
      r.last = 1'b1;
      r.failed_count = count_timed_out();
      expected_rsps.push_back(r);
   endfunction

   function automatic void push_entry(int e);
      hb_rsp_t r;
      logic [5:0] fc;
      fc = count_timed_out();
      for (int k = 0; k < READ_LEN; k++) begin
         r.status = STATUS_OK;
         r.entry_addr = node_addr_q[e];
         r.entry_type = node_type_q[e];
         r.elapsed = ticks_q[e];
         r.reported = mark_q[e];
         r.out_byte = bytes_q[e][k];
         r.out_index = 3'(k);
         r.last = (k == READ_LEN - 1);
         r.failed_count = fc;
         expected_rsps.push_back(r);
      end
   endfunction

   function automatic void predict_table(hb_cmd_t c);
      int e;
      bit bad;
      e = int'(c.addr) - 1;
      bad = (c.addr == 0) || (c.addr > NODES);
      case (c.kind)
         KIND_STAMP: begin
            if (bad) push_short(STATUS_BAD);
            else begin
               node_addr_q[e] = c.addr;
               node_type_q[e] = c.dev_type;
               if (c.has_data) bytes_q[e][c.index] = c.data;
               ticks_q[e] = '0;
               mark_q[e] = 1'b0;
               push_short(STATUS_OK);
            end
         end
         KIND_TICK: begin
            for (int i = 0; i < NODES; i++)
               if (ticks_q[i] != TIMER_TOP) ticks_q[i]++;
            push_short(STATUS_OK);
         end
         KIND_TAKE: begin
            e = -1;
            for (int i = NODES - 1; i >= 0 && e < 0; i--)
               if (ticks_q[i] > limit_q && !mark_q[i]) e = i;
            if (e < 0) push_short(STATUS_NONE);
            else begin
               mark_q[e] = 1'b1;
               push_entry(e);
            end
         end
         default: begin
            if (bad) push_short(STATUS_BAD);
            else push_entry(e);
         end
      endcase
   endfunction

   // driver
   always @(negedge clock) begin
      if (reset) start <= 1'b0;
      else if (start && !accept_seen) begin
         // word still waiting, hold it
      end else if (pending_cmds.size() != 0 &&
                   (quiet_drive || $urandom_range(99) >= 6)) begin
         hb_cmd_t c;
         c = pending_cmds.pop_front();
         start <= 1'b1;
         req_kind <= c.kind;
         req_device_addr <= c.addr;
         req_device_type <= c.dev_type;
         req_has_data <= c.has_data;
         req_data_byte <= c.data;
         req_byte_index <= c.index;
         req_last_byte <= c.last_byte;
      end else start <= 1'b0;
   end

   // monitor: accept, predict, check
   always @(posedge clock) begin
      accept_seen <= !reset && start && !busy;
      if (!reset) begin
         if (rsp_valid) begin
            hb_rsp_t got, exp_r;
            got = {rsp_status, rsp_entry_addr, rsp_entry_type, rsp_elapsed,
                   rsp_reported, rsp_out_byte, rsp_out_index, rsp_last,
                   rsp_failed_count};
            if (expected_rsps.size() == 0) begin
               errors++;
               $display("%0t: unexpected result %h", $time, got);
            end else begin
               exp_r = expected_rsps.pop_front();
               if (got != exp_r) begin
                  errors++;
                  $display("%0t: mismatch expected %h actual %h", $time, exp_r, got);
               end
            end
         end
         if (start && !busy) begin
            hb_cmd_t c;
            c = {kind_type'(req_kind), req_device_addr, req_device_type,
                 req_has_data, req_data_byte, req_byte_index, req_last_byte};
            predict_table(c);
            accepted++;
         end
         if (csr_valid && csr_ready) limit_q <= csr_data;
      end
   end

   function automatic hb_cmd_t make_cmd(kind_type k, int a);
      hb_cmd_t c;
      c.kind = k;
      c.addr = 8'(a);
      c.dev_type = 8'($urandom);
      c.has_data = 1'($urandom);
      c.data = 8'($urandom);
      c.index = 3'($urandom);
      c.last_byte = 1'($urandom);
      return c;
   endfunction

   task automatic run_and_drain();
      while (pending_cmds.size() != 0 || start) @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (45) @(posedge clock);
   endtask

   task automatic write_limit(logic [15:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic add_random(int n, int tick_weight);
      hb_cmd_t c;
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < tick_weight) c = make_cmd(KIND_TICK, $urandom);
         else if (r < tick_weight + 35) c = make_cmd(KIND_STAMP, $urandom_range(1, NODES));
         else if (r < tick_weight + 55) c = make_cmd(KIND_TAKE, $urandom);
         else if (r < tick_weight + 60) c = make_cmd(kind_type'(3 * $urandom_range(1)),
                                                     $urandom);
         else c = make_cmd(KIND_READ, $urandom_range(1, NODES));
         pending_cmds.push_back(c);
      end
   endtask

   initial begin
      hb_cmd_t c;
      limit_q = 16'd1000;
      for (int i = 0; i < NODES; i++) begin
         node_addr_q[i] = '0; node_type_q[i] = '0; ticks_q[i] = '0; mark_q[i] = 1'b0;
         for (int k = 0; k < READ_LEN; k++) bytes_q[i][k] = '0;
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reads of fresh table, bad addresses, extremes
      pending_cmds.push_back(make_cmd(KIND_READ, 1));
      pending_cmds.push_back(make_cmd(KIND_READ, 0));
      pending_cmds.push_back(make_cmd(KIND_READ, NODES + 1));
      pending_cmds.push_back(make_cmd(KIND_STAMP, 0));
      pending_cmds.push_back(make_cmd(KIND_STAMP, 255));
      pending_cmds.push_back(make_cmd(KIND_TAKE, 5));
      c = make_cmd(KIND_STAMP, NODES); c.has_data = 1; c.index = 7; c.data = 8'hff;
      c.dev_type = 8'hff; c.last_byte = 1;
      pending_cmds.push_back(c);
      c = make_cmd(KIND_STAMP, 1); c.has_data = 1; c.index = 0; c.data = 8'h00;
      c.dev_type = 8'h00; c.last_byte = 0;
      pending_cmds.push_back(c);
      c = make_cmd(KIND_STAMP, 1); c.has_data = 0; c.data = 8'h5a;
      pending_cmds.push_back(c);
      pending_cmds.push_back(make_cmd(KIND_READ, NODES));
      pending_cmds.push_back(make_cmd(KIND_TICK, 0));
      run_and_drain();

      // limit 0: one tick times everything out, then four takes and a read
      write_limit(16'd0);
      pending_cmds.push_back(make_cmd(KIND_TICK, 3));
      for (int i = 0; i < 4; i++) pending_cmds.push_back(make_cmd(KIND_TAKE, 0));
      pending_cmds.push_back(make_cmd(KIND_READ, NODES));
      run_and_drain();

      write_limit(16'd3);
      add_random(120, 30);
      run_and_drain();

      // no idling stretch
      quiet_drive = 1'b1;
      write_limit(16'd1);
      add_random(80, 25);
      run_and_drain();
      quiet_drive = 1'b0;

      write_limit(16'd65535);
      add_random(40, 30);
      run_and_drain();

      write_limit(16'd8);
      add_random(110, 35);
      run_and_drain();

      if (errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #20ms;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
`default_nettype wire

// File: sim.f
design/hbt_pkg.sv
design/hbt_cell.sv
design/node_heartbeat_timeout_table.sv
design/hbt_checker.sv
sim/tb_node_heartbeat_timeout_table.sv
